// ----- rtl/gap_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package gap_pkg;
	localparam int GRID_ROWS_DEF = 8;
	localparam int GRID_COLS_DEF = 8;
	localparam int CELL_W = 6;
	localparam int NCELLS = 64;
	localparam logic [15:0] STEP_STRAIGHT = 16'd256;
	localparam logic [15:0] STEP_DIAG = 16'd362;

	localparam logic [1:0] ST_CELL = 2'd0;
	localparam logic [1:0] ST_NOPATH = 2'd1;
	localparam logic [1:0] ST_BADPOS = 2'd2;
	localparam logic [1:0] ST_SAME = 2'd3;

	localparam logic FUNC_LOAD = 1'b0;

	typedef enum logic [3:0] {
		S_IDLE, S_CLEAR, S_SCAN, S_SCAN_END, S_NB, S_NB_RD, S_NB_UPD,
		S_TRACE_RD, S_TRACE, S_EMIT_RD, S_EMIT, S_STATUS
	} state_t;

	// round(sqrt(dr*dr+dc*dc)*256), exact integer root rounded to nearest
	function automatic logic [15:0] heur_calc(input logic [2:0] dr, input logic [2:0] dc);
		logic [31:0] x, s, t;
		begin
			x = ({29'd0, dr} * {29'd0, dr} + {29'd0, dc} * {29'd0, dc}) << 16;
			s = 32'd0;
			for (int b = 12; b >= 0; b--) begin
				t = s | (32'd1 << b);
				if (t * t <= x) s = t;
			end
			if (x - s * s > s) s = s + 32'd1;
			heur_calc = s[15:0];
		end
	endfunction

	function automatic logic [NCELLS*16-1:0] heur_fill();
		logic [NCELLS*16-1:0] tab;
		begin
			tab = '0;
			for (int i = 0; i < NCELLS; i++)
				tab[i*16 +: 16] = heur_calc(3'(i >> 3), 3'(i & 7));
			heur_fill = tab;
		end
	endfunction

	localparam logic [NCELLS*16-1:0] HEUR_TAB = heur_fill();

	// heuristic in Q8.8, constant table indexed by dr*8+dc
	function automatic logic [15:0] heur(input logic [2:0] dr, input logic [2:0] dc);
		heur = HEUR_TAB[{dr, dc, 4'd0} +: 16];
	endfunction
endpackage
`default_nettype wire

// ----- rtl/gap_cost_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
module gap_cost_ram import gap_pkg::*; (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [CELL_W-1:0] waddr,
	input  wire logic [37:0]       wdata,
	input  wire logic [CELL_W-1:0] raddr,
	output logic      [37:0]       rdata
);
	// {parent, g, f} per cell
	logic [37:0] mem [NCELLS];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ----- rtl/grid_astar_path_search.sv -----
`timescale 1ns / 1ps
`default_nettype none
// channel | valid    | stall    | fields
// in      | in_valid | in_stall | func load_row row_free_bits src_row src_col dst_row dst_col
// out     | valid    | stall    | status cell_row cell_col last
// Loads write a row when taken; bad-position or same-cell status shows the cycle after.
// A search clears its marks, then per expansion scans all cells through the single
// cost memory read port and visits 8 neighbors until it meets the goal, reading those
// inside the grid; then it traces the parent chain backward and emits it forward.
// Reset clears the grid to all blocked; the cost memory needs no reset.
// While stall holds, the emitting state waits; no new item is taken.
module grid_astar_path_search import gap_pkg::*; #(
	parameter int GRID_ROWS = GRID_ROWS_DEF,
	parameter int GRID_COLS = GRID_COLS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic       func,
	input  wire logic [2:0] load_row,
	input  wire logic [7:0] row_free_bits,
	input  wire logic [3:0] src_row,
	input  wire logic [3:0] src_col,
	input  wire logic [3:0] dst_row,
	input  wire logic [3:0] dst_col,
	output logic            valid,
	input  wire logic       stall,
	output logic [1:0]      status,
	output logic [2:0]      cell_row,
	output logic [2:0]      cell_col,
	output logic            last
);
	state_t state_q, state_d;
	logic [7:0] grid_q [8];
	logic [NCELLS-1:0] open_q, closed_q, cval_q;
	logic [2:0] gr_q, gc_q;
	logic [6:0] scan_q;
	logic [5:0] best_q;
	logic [15:0] best_f_q, best_g_q;
	logic found_q;
	logic [2:0] k_q;
	logic [5:0] nb_q;
	logic [15:0] f2_q, g2_q;
	logic [5:0] chain_q [NCELLS];
	logic [5:0] chain_rd_q;
	logic [6:0] n_q, e_q;
	logic [5:0] cur_q;
	logic [1:0] stat_q;

	logic we;
	logic [5:0] waddr, raddr;
	logic [37:0] wdata, rdata;
	gap_cost_ram u_ram (.clk, .we, .waddr, .wdata, .raddr, .rdata);

	logic in_acc, out_acc;
	assign in_acc = in_valid && !in_stall;
	assign out_acc = valid && !stall;
	assign in_stall = (state_q != S_IDLE);

	logic [NCELLS-1:0] src_bit;
	assign src_bit = {{(NCELLS-1){1'b0}}, 1'b1} << best_q;

	// neighbor geometry
	logic signed [4:0] nr, nc;
	logic nb_in;
	logic [5:0] nb;
	always_comb begin
		nr = $signed({2'b0, best_q[5:3]});
		nc = $signed({2'b0, best_q[2:0]});
		unique case (k_q)
			3'd0: nr = nr - 5'sd1;
			3'd1: nr = nr + 5'sd1;
			3'd2: nc = nc + 5'sd1;
			3'd3: nc = nc - 5'sd1;
			3'd4: begin nr = nr - 5'sd1; nc = nc + 5'sd1; end
			3'd5: begin nr = nr - 5'sd1; nc = nc - 5'sd1; end
			3'd6: begin nr = nr + 5'sd1; nc = nc + 5'sd1; end
			default: begin nr = nr + 5'sd1; nc = nc - 5'sd1; end
		endcase
		nb_in = nr >= 0 && nr < GRID_ROWS && nc >= 0 && nc < GRID_COLS;
		nb = {nr[2:0], nc[2:0]};
	end

	logic [2:0] adr, adc;
	logic [15:0] g_base, g2, f2;
	always_comb begin
		adr = (nr[2:0] > gr_q) ? nr[2:0] - gr_q : gr_q - nr[2:0];
		adc = (nc[2:0] > gc_q) ? nc[2:0] - gc_q : gc_q - nc[2:0];
		// on the first neighbor the expanded cell's g is still on the read port
		g_base = (k_q == 3'd0) ? rdata[31:16] : best_g_q;
		g2 = g_base + ((k_q < 3'd4) ? STEP_STRAIGHT : STEP_DIAG);
		f2 = g2 + heur(adr, adc);
	end

	logic [5:0] scan_cell;
	assign scan_cell = scan_q[5:0] - 6'd1;

	always_comb begin
		state_d = state_q;
		we = 1'b0;
		waddr = nb_q;
		wdata = {best_q, g2_q, f2_q};
		raddr = scan_q[5:0];
		unique case (state_q)
			S_IDLE: if (in_acc) begin
				if (func == FUNC_LOAD) state_d = S_IDLE;
				else if (src_row >= GRID_ROWS || src_col >= GRID_COLS ||
					dst_row >= GRID_ROWS || dst_col >= GRID_COLS) state_d = S_STATUS;
				else if (src_row == dst_row && src_col == dst_col) state_d = S_STATUS;
				else state_d = S_CLEAR;
			end
			S_CLEAR: begin
				we = 1'b1;
				waddr = best_q;
				wdata = {best_q, 32'd0};
				state_d = S_SCAN;
			end
			S_SCAN: if (scan_q == 7'(NCELLS)) state_d = S_SCAN_END;
			S_SCAN_END: begin
				raddr = best_q;
				state_d = found_q ? S_NB : S_STATUS;
			end
			S_NB: begin
				raddr = nb;
				if (!nb_in) state_d = (k_q == 3'd7) ? S_SCAN : S_NB;
				else if (nb[5:3] == gr_q && nb[2:0] == gc_q) state_d = S_TRACE_RD;
				else state_d = S_NB_RD;
			end
			S_NB_RD: begin
				raddr = nb_q;
				state_d = S_NB_UPD;
			end
			S_NB_UPD: begin
				we = !closed_q[nb_q] && grid_q[nb_q[5:3]][nb_q[2:0]] &&
					(!cval_q[nb_q] || rdata[15:0] > f2_q);
				state_d = (k_q == 3'd0) ? S_SCAN : S_NB;
			end
			S_TRACE_RD: begin
				raddr = cur_q;
				state_d = S_TRACE;
			end
			S_TRACE: begin
				raddr = rdata[37:32];
				state_d = (rdata[37:32] == cur_q || n_q == 7'(NCELLS - 1)) ? S_EMIT_RD
					: S_TRACE_RD;
			end
			S_EMIT_RD: state_d = S_EMIT;
			S_EMIT: if (out_acc) state_d = (e_q == 7'd1) ? S_IDLE : S_EMIT_RD;
			S_STATUS: if (out_acc) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	assign valid = (state_q == S_EMIT) || (state_q == S_STATUS);
	assign status = (state_q == S_EMIT) ? ST_CELL : stat_q;
	assign cell_row = (state_q == S_EMIT) ? chain_rd_q[5:3] : 3'd0;
	assign cell_col = (state_q == S_EMIT) ? chain_rd_q[2:0] : 3'd0;
	assign last = (state_q == S_STATUS) || (e_q == 7'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) grid_q[i] <= 8'd0;
			open_q <= '0;
			closed_q <= '0;
			cval_q <= '0;
		end else begin
			if (state_q == S_IDLE && in_acc && func == FUNC_LOAD && load_row < GRID_ROWS)
				grid_q[load_row] <= row_free_bits;
			if (state_q == S_CLEAR) begin
				open_q <= src_bit;
				closed_q <= '0;
				cval_q <= src_bit;
			end
			if (state_q == S_SCAN_END && found_q) begin
				open_q[best_q] <= 1'b0;
				closed_q[best_q] <= 1'b1;
			end
			if (we && state_q == S_NB_UPD) begin
				open_q[nb_q] <= 1'b1;
				cval_q[nb_q] <= 1'b1;
			end
		end
	end

	// path cell for the pending result; address holds while the result waits
	always_ff @(posedge clk) begin
		chain_rd_q <= chain_q[e_q[5:0] - 6'd1];
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				gr_q <= dst_row[2:0];
				gc_q <= dst_col[2:0];
				best_q <= {src_row[2:0], src_col[2:0]};
				cur_q <= {dst_row[2:0], dst_col[2:0]};
				scan_q <= 7'd0;
				found_q <= 1'b0;
				stat_q <= (src_row >= GRID_ROWS || src_col >= GRID_COLS ||
					dst_row >= GRID_ROWS || dst_col >= GRID_COLS) ? ST_BADPOS : ST_SAME;
			end
			S_SCAN: begin
				// read data is registered, so it belongs to the previous scan address
				if (scan_q != 7'd0 && open_q[scan_cell] &&
					(!found_q || rdata[15:0] < best_f_q)) begin
					best_q <= scan_cell;
					best_f_q <= rdata[15:0];
					found_q <= 1'b1;
				end
				scan_q <= scan_q + 7'd1;
				k_q <= 3'd0;
			end
			S_SCAN_END: begin
				scan_q <= 7'd0;
				stat_q <= ST_NOPATH;
			end
			S_NB: begin
				if (k_q == 3'd0) best_g_q <= rdata[31:16];
				nb_q <= nb;
				g2_q <= g2;
				f2_q <= f2;
				k_q <= k_q + 3'd1;
				if (!nb_in && k_q == 3'd7) found_q <= 1'b0;
				if (nb_in && nb[5:3] == gr_q && nb[2:0] == gc_q) begin
					chain_q[0] <= nb;
					n_q <= 7'd1;
					cur_q <= best_q;
				end
			end
			S_NB_UPD: if (k_q == 3'd0) found_q <= 1'b0;
			S_TRACE: begin
				chain_q[n_q[5:0]] <= cur_q;
				n_q <= n_q + 7'd1;
				cur_q <= rdata[37:32];
				if (rdata[37:32] == cur_q || n_q == 7'(NCELLS - 1)) e_q <= n_q + 7'd1;
			end
			S_EMIT: if (out_acc) e_q <= e_q - 7'd1;
			default: ;
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n) valid |-> in_stall)
		else $error("result shown while idle");
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid && stall) |=> valid)
		else $error("result dropped under stall");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT) |-> (e_q != 7'd0))
		else $error("emit count empty");
	assert property (@(posedge clk) disable iff (!arst_n)
		(open_q & closed_q) == '0)
		else $error("cell both open and closed");
endmodule
`default_nettype wire

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
	import gap_pkg::*;

	localparam logic FUNC_SEARCH = 1'b1;
	localparam int MOVE_DR[8] = '{-1, 1, 0, 0, -1, -1, 1, 1};
	localparam int MOVE_DC[8] = '{0, 0, 1, -1, 1, -1, 1, -1};
	localparam int QUIET_LO = 70;
	localparam int QUIET_HI = 110;

	typedef struct packed {
		logic [1:0] status;
		logic [2:0] row;
		logic [2:0] col;
		logic       last;
	} path_res_t;

	typedef struct {
		logic       func;
		logic [2:0] lrow;
		logic [7:0] bits;
		logic [3:0] sr, sc, gr, gc;
		bit         drain_first;
	} query_t;

	class path_scoreboard;
		bit [7:0]  free_map[8];
		bit        closed[64], opened[64], known[64];
		bit [15:0] g_cost[64], f_cost[64];
		bit [5:0]  parent[64];
		path_res_t expected_q[$];
		int        n_loads, n_searches, n_results;

		function bit [15:0] euclid_q88(int r, int c, int gr, int gc);
			int unsigned dr, dc, x, s, t;
			dr = (r > gr) ? r - gr : gr - r;
			dc = (c > gc) ? c - gc : gc - c;
			x = (dr * dr + dc * dc) << 16;
			s = 0;
			for (int b = 12; b >= 0; b--) begin
				t = s | (1 << b);
				if (t * t <= x) s = t;
			end
			if (x - s * s > s) s++;
			return s[15:0];
		endfunction

		function void push(logic [1:0] st, int r, int c, bit lst);
			path_res_t e;
			e.status = st;
			e.row = r[2:0];
			e.col = c[2:0];
			e.last = lst;
			expected_q.push_back(e);
		endfunction

		function void trace_path(int goal);
			int chain[$];
			int cur;
			cur = goal;
			while (chain.size() < 63 && parent[cur] != cur) begin
				chain.push_front(cur);
				cur = parent[cur];
			end
			chain.push_front(cur);
			foreach (chain[k])
				push(ST_CELL, chain[k] >> 3, chain[k] & 7, k == chain.size() - 1);
		endfunction

		function void note_input(query_t q);
			int sr, sc, gr, gc, best, r, c, nr, nc, n;
			bit [15:0] best_f;
			int unsigned g2, f2;
			if (q.func == FUNC_LOAD) begin
				free_map[q.lrow] = q.bits;
				n_loads++;
				return;
			end
			n_searches++;
			sr = q.sr; sc = q.sc; gr = q.gr; gc = q.gc;
			if (sr >= 8 || sc >= 8 || gr >= 8 || gc >= 8) begin
				push(ST_BADPOS, 0, 0, 1);
				return;
			end
			if (sr == gr && sc == gc) begin
				push(ST_SAME, 0, 0, 1);
				return;
			end
			for (int i = 0; i < 64; i++) begin
				closed[i] = 0; opened[i] = 0; known[i] = 0;
			end
			n = sr * 8 + sc;
			g_cost[n] = '0; f_cost[n] = '0; known[n] = 1; opened[n] = 1; parent[n] = 6'(n);
			forever begin
				best = 64;
				best_f = 0;
				for (int i = 0; i < 64; i++)
					if (opened[i] && (best == 64 || f_cost[i] < best_f)) begin
						best = i;
						best_f = f_cost[i];
					end
				if (best == 64) begin
					push(ST_NOPATH, 0, 0, 1);
					return;
				end
				opened[best] = 0;
				closed[best] = 1;
				r = best >> 3;
				c = best & 7;
				for (int k = 0; k < 8; k++) begin
					nr = r + MOVE_DR[k];
					nc = c + MOVE_DC[k];
					if (nr < 0 || nr >= 8 || nc < 0 || nc >= 8) continue;
					n = nr * 8 + nc;
					if (nr == gr && nc == gc) begin
						parent[n] = 6'(best);
						trace_path(n);
						return;
					end
					if (closed[n] || !free_map[nr][nc]) continue;
					g2 = g_cost[best] + (k < 4 ? STEP_STRAIGHT : STEP_DIAG);
					f2 = g2 + euclid_q88(nr, nc, gr, gc);
					if (!known[n] || f_cost[n] > f2) begin
						g_cost[n] = g2[15:0];
						f_cost[n] = f2[15:0];
						parent[n] = 6'(best);
						known[n] = 1;
						opened[n] = 1;
					end
				end
			end
		endfunction

		// returns an empty string when the result matches
		function string check_result(path_res_t got);
			path_res_t e;
			n_results++;
			if (expected_q.size() == 0)
				return $sformatf("unexpected result %p", got);
			e = expected_q.pop_front();
			if (got.status != e.status || got.row != e.row || got.col != e.col
					|| got.last != e.last)
				return $sformatf("result %0d: got %p, want %p", n_results, got, e);
			return "";
		endfunction
	endclass

	logic       clk = 0;
	logic       arst_n = 0;
	logic       in_valid = 0;
	logic       in_stall;
	logic       func = FUNC_LOAD;
	logic [2:0] load_row = 0;
	logic [7:0] row_free_bits = 0;
	logic [3:0] src_row = 0, src_col = 0, dst_row = 0, dst_col = 0;
	logic       valid;
	logic       stall = 1;
	logic [1:0] status;
	logic [2:0] cell_row, cell_col;
	logic       last;

	grid_astar_path_search uut (.*);

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	path_scoreboard sb = new();
	query_t stim_q[$];
	int     stim_idx = 0;
	int     n_errors = 0;
	int     hold_left = 0;
	bit     hold_done = 0;

	task report(string msg);
		$display("ERROR %0t: %s", $realtime, msg);
		n_errors++;
	endtask

	task add_load(int r, int bits);
		query_t q;
		q = '{default: 0};
		q.func = FUNC_LOAD;
		q.lrow = 3'(r);
		q.bits = 8'(bits);
		q.sr = 4'($urandom); q.sc = 4'($urandom); q.gr = 4'($urandom); q.gc = 4'($urandom);
		stim_q.push_back(q);
	endtask

	task add_search(int sr, int sc, int gr, int gc, bit drain);
		query_t q;
		q.func = FUNC_SEARCH;
		q.lrow = 3'($urandom);
		q.bits = 8'($urandom);
		q.sr = 4'(sr); q.sc = 4'(sc); q.gr = 4'(gr); q.gc = 4'(gc);
		q.drain_first = drain;
		stim_q.push_back(q);
	endtask

	function int rand_coord();
		return ($urandom_range(0, 99) < 88) ? $urandom_range(0, 7) : $urandom_range(8, 15);
	endfunction

	// sender: holds payload while stalled
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 0;
		end else begin
			bit busy;
			busy = in_valid && in_stall;
			if (in_valid && !in_stall) begin
				sb.note_input(stim_q[stim_idx]);
				stim_idx++;
			end
			if (!busy) begin
				int nxt;
				nxt = stim_idx;
				if (nxt < stim_q.size()
						&& !(stim_q[nxt].drain_first && (sb.expected_q.size() != 0 || valid))
						&& (nxt >= QUIET_LO && nxt < QUIET_HI || $urandom_range(0, 99) >= 38)) begin
					in_valid <= 1;
					func <= stim_q[nxt].func;
					load_row <= stim_q[nxt].lrow;
					row_free_bits <= stim_q[nxt].bits;
					src_row <= stim_q[nxt].sr;
					src_col <= stim_q[nxt].sc;
					dst_row <= stim_q[nxt].gr;
					dst_col <= stim_q[nxt].gc;
				end else begin
					in_valid <= 0;
				end
			end
		end
	end

	// receiver: random stall, one long hold-off, quiet window
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stall <= 1;
		end else begin
			if (valid && !stall) begin
				string msg;
				msg = sb.check_result('{status, cell_row, cell_col, last});
				if (msg != "") report(msg);
			end
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				stall <= 1;
			end else if (!hold_done && sb.n_results >= 40) begin
				hold_done <= 1;
				hold_left <= 3000;
				stall <= 1;
			end else if (stim_idx >= QUIET_LO && stim_idx < QUIET_HI) begin
				stall <= 0;
			end else begin
				stall <= ($urandom_range(0, 99) < 38);
			end
		end
	end

	initial begin
		// directed: open grid, corners, status cases
		for (int r = 0; r < 8; r++) add_load(r, 8'hFF);
		add_search(0, 0, 7, 7, 0);
		add_search(7, 7, 0, 0, 0);
		add_search(0, 7, 7, 0, 0);
		add_search(3, 3, 3, 3, 0);
		add_search(8, 0, 1, 1, 0);
		add_search(0, 15, 1, 1, 0);
		add_search(1, 1, 15, 0, 0);
		add_search(2, 2, 0, 8, 0);
		add_load(4, 8'h00);                // wall across row 4
		add_search(0, 3, 7, 3, 0);
		add_search(0, 3, 4, 5, 0);          // blocked goal
		add_search(4, 2, 0, 0, 0);          // blocked source
		add_load(5, 8'h00);
		add_search(7, 7, 0, 0, 0);          // no path
		add_load(4, 8'hAA);
		add_load(5, 8'h55);
		add_search(7, 0, 0, 7, 1);
		// random: mostly searches on fairly open grids
		for (int i = 0; i < 185; i++) begin
			if ($urandom_range(0, 99) < 22)
				add_load($urandom_range(0, 7), $urandom | $urandom | ($urandom & $urandom));
			else
				add_search(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
					$urandom_range(0, 99) < 4);
		end
		repeat (10) @(posedge clk);
		arst_n <= 1;
		wait (stim_idx == stim_q.size());
		wait (sb.expected_q.size() == 0);
		repeat (300) @(posedge clk);
		$display("Covered %0d loads and %0d searches, %0d results checked.",
			sb.n_loads, sb.n_searches, sb.n_results);
		if (n_errors == 0 && sb.expected_q.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#400ms;
		$display("Timeout with %0d items sent, %0d results pending.",
			stim_idx, sb.expected_q.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
